/* rtl/tccf_pkg.sv */
// Shared types, constants and the digit color table for the tick clock.
// Used by every module of the frame generator; depends on nothing.
package tccf_pkg;

    // Frame layout
    localparam int FRAME_WORDS = 13;
    localparam int WORD_IDX_W  = 4;
    localparam logic [WORD_IDX_W-1:0] WORD_CMD  = '0;
    localparam logic [WORD_IDX_W-1:0] WORD_LAST = WORD_IDX_W'(FRAME_WORDS - 1);

    // Descriptor queue depth between front and back
    localparam int QUEUE_DEPTH_DEFAULT = 2;

    // Register file
    localparam int CFG_INDEX_W = 8;
    localparam int CFG_DATA_W  = 16;

    typedef enum logic [CFG_INDEX_W-1:0] {
        CFG_TICK_LIMIT    = 8'd0,
        CFG_FRAME_COMMAND = 8'd1
    } cfg_reg_t;

    localparam logic [15:0] TICK_LIMIT_RESET    = 16'd500;
    localparam logic [15:0] FRAME_COMMAND_RESET = 16'd0;

    // Time of day
    localparam logic [5:0] SECONDS_RESET = 6'd3;
    localparam logic [5:0] MINUTES_RESET = 6'd11;
    localparam logic [4:0] HOURS_RESET   = 5'd10;
    localparam logic [5:0] SECONDS_WRAP  = 6'd60;
    localparam logic [5:0] MINUTES_WRAP  = 6'd60;
    localparam logic [4:0] HOURS_WRAP    = 5'd24;

    // One frame worth of work: command word and the three digits shown
    typedef struct packed {
        logic [15:0] command;
        logic [3:0]  sec_units;
        logic [3:0]  sec_tens;
        logic [3:0]  min_units;
    } frame_desc_t;

    // Resistor color code, R, G, B per digit
    localparam logic [15:0] COLOR_RGB [10][3] = '{
        '{16'h0000, 16'h0000, 16'h0000},
        '{16'h8CCC, 16'h2666, 16'h0000},
        '{16'hFFFF, 16'h0000, 16'h0000},
        '{16'hFFFF, 16'hA665, 16'h0000},
        '{16'hFFFF, 16'hFFFF, 16'h0000},
        '{16'h0000, 16'hFFFF, 16'h0000},
        '{16'h0000, 16'h0000, 16'hFFFF},
        '{16'hEE13, 16'h828E, 16'hEE13},
        '{16'h3333, 16'h3333, 16'h3333},
        '{16'hFFFF, 16'hFFFF, 16'hFFFF}
    };

    // Color channel word of a digit; digits above nine show as nine
    function automatic logic [15:0] color_word(input logic [3:0] digit, input logic [1:0] chan);
        logic [3:0] d;
        logic [15:0] w;
        d = (digit > 4'd9) ? 4'd9 : digit;
        case (chan)
            2'd0:    w = COLOR_RGB[d][0];
            2'd1:    w = COLOR_RGB[d][1];
            2'd2:    w = COLOR_RGB[d][2];
            default: w = 16'h0000;
        endcase
        return w;
    endfunction

endpackage

/* rtl/tccf_front.sv */
// Front end of the tick clock: register file, tick counter and time of day.
// Turns each firing tick into a frame descriptor. Depends on tccf_pkg.
module tccf_front (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                push,
    input  logic                                tick,
    input  logic                                cfg_valid,
    input  logic [tccf_pkg::CFG_INDEX_W-1:0]    cfg_index,
    input  logic [tccf_pkg::CFG_DATA_W-1:0]     cfg_data,
    input  logic                                q_full,
    output logic                                q_push,
    output tccf_pkg::frame_desc_t               q_desc
);
    import tccf_pkg::*;

    logic [15:0] tick_limit_reg;
    logic [15:0] frame_command_reg;
    logic [15:0] tick_count_reg, tick_count_next;
    logic [5:0]  seconds_reg, seconds_next;
    logic [5:0]  minutes_reg, minutes_next;
    logic [4:0]  hours_reg, hours_next;

    logic        accept;
    logic        fire;
    logic [5:0]  sec_inc, min_carry, min_inc;
    logic [4:0]  hrs_carry, hrs_inc;
    logic [3:0]  sec_tens, sec_units, min_tens, min_units;

    // Take a word whenever the queue has room; only a firing tick fills a slot
    assign accept = push && !q_full;
    assign fire   = tick && (tick_count_reg >= tick_limit_reg);
    assign q_push = accept && fire;

    // Split seconds and minutes into decimal digits
    always_comb
    begin
        sec_tens = (seconds_reg >= 6'd60) ? 4'd6 : (seconds_reg >= 6'd50) ? 4'd5 :
                   (seconds_reg >= 6'd40) ? 4'd4 : (seconds_reg >= 6'd30) ? 4'd3 :
                   (seconds_reg >= 6'd20) ? 4'd2 : (seconds_reg >= 6'd10) ? 4'd1 : 4'd0;
        min_tens = (minutes_reg >= 6'd60) ? 4'd6 : (minutes_reg >= 6'd50) ? 4'd5 :
                   (minutes_reg >= 6'd40) ? 4'd4 : (minutes_reg >= 6'd30) ? 4'd3 :
                   (minutes_reg >= 6'd20) ? 4'd2 : (minutes_reg >= 6'd10) ? 4'd1 : 4'd0;
        sec_units = 4'(seconds_reg - ({2'b00, sec_tens} * 6'd10));
        min_units = 4'(minutes_reg - ({2'b00, min_tens} * 6'd10));
    end

    assign q_desc.command   = frame_command_reg;
    assign q_desc.sec_units = sec_units;
    assign q_desc.sec_tens  = sec_tens;
    assign q_desc.min_units = min_units;

    // Advance seconds, minutes and hours with their wraps
    always_comb
    begin
        sec_inc   = seconds_reg + 6'd1;
        min_carry = minutes_reg;
        if (sec_inc >= SECONDS_WRAP)
        begin
            sec_inc   = '0;
            min_carry = minutes_reg + 6'd1;
        end
        min_inc   = min_carry;
        hrs_carry = hours_reg;
        if (min_carry >= MINUTES_WRAP)
        begin
            min_inc   = '0;
            hrs_carry = hours_reg + 5'd1;
        end
        hrs_inc = (hrs_carry >= HOURS_WRAP) ? 5'd0 : hrs_carry;
    end

    // Next count and time for an accepted word
    always_comb
    begin
        tick_count_next = tick_count_reg;
        seconds_next    = seconds_reg;
        minutes_next    = minutes_reg;
        hours_next      = hours_reg;
        if (accept && tick)
        begin
            if (fire)
            begin
                tick_count_next = '0;
                seconds_next    = sec_inc;
                minutes_next    = min_inc;
                hours_next      = hrs_inc;
            end
            else
            begin
                tick_count_next = tick_count_reg + 16'd1;
            end
        end
    end

    // Hold state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tick_count_reg <= '0;
            seconds_reg    <= SECONDS_RESET;
            minutes_reg    <= MINUTES_RESET;
            hours_reg      <= HOURS_RESET;
        end
        else
        begin
            tick_count_reg <= tick_count_next;
            seconds_reg    <= seconds_next;
            minutes_reg    <= minutes_next;
            hours_reg      <= hours_next;
        end
    end

    // Write registers; drop unknown indexes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tick_limit_reg    <= TICK_LIMIT_RESET;
            frame_command_reg <= FRAME_COMMAND_RESET;
        end
        else if (cfg_valid)
        begin
            case (cfg_index)
                CFG_TICK_LIMIT:    tick_limit_reg    <= cfg_data;
                CFG_FRAME_COMMAND: frame_command_reg <= cfg_data;
                default:           ;
            endcase
        end
    end

    // A firing tick always restarts the count
    assert property (@(posedge clk) disable iff (!rst_n)
        q_push |=> (tick_count_reg == 16'd0))
        else $error("count not cleared after frame");

    // Time of day stays in range
    assert property (@(posedge clk) disable iff (!rst_n)
        (seconds_reg < SECONDS_WRAP) && (minutes_reg < MINUTES_WRAP) && (hours_reg < HOURS_WRAP))
        else $error("time of day out of range");

    // Nothing moves while the queue refuses words
    assert property (@(posedge clk) disable iff (!rst_n)
        q_full |=> $stable(tick_count_reg) && $stable(seconds_reg))
        else $error("state advanced while full");

endmodule

/* rtl/tccf_queue.sv */
// Short descriptor queue between the front end and the frame sequencer.
// Depends on tccf_pkg for the descriptor type.
module tccf_queue #(
    parameter int QUEUE_DEPTH = tccf_pkg::QUEUE_DEPTH_DEFAULT
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  q_push,
    input  tccf_pkg::frame_desc_t q_desc_in,
    output logic                  q_full,
    input  logic                  q_pop,
    output logic                  q_valid,
    output tccf_pkg::frame_desc_t q_desc_out
);
    import tccf_pkg::*;

    localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);
    localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(QUEUE_DEPTH - 1);
    localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(QUEUE_DEPTH);

    frame_desc_t       slot_reg [QUEUE_DEPTH];
    logic [PTR_W-1:0]  wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0]  rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0]  count_reg, count_next;
    logic              do_push, do_pop;

    assign q_full     = (count_reg == CNT_FULL);
    assign q_valid    = (count_reg != '0);
    assign q_desc_out = slot_reg[rd_ptr_reg];
    assign do_push    = q_push && !q_full;
    assign do_pop     = q_pop && q_valid;

    // Advance pointers and fill count
    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push)
            wr_ptr_next = (wr_ptr_reg == PTR_LAST) ? '0 : wr_ptr_reg + 1'b1;
        if (do_pop)
            rd_ptr_next = (rd_ptr_reg == PTR_LAST) ? '0 : rd_ptr_reg + 1'b1;
        if (do_push && !do_pop)
            count_next = count_reg + 1'b1;
        else if (do_pop && !do_push)
            count_next = count_reg - 1'b1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // Store descriptors
    always_ff @(posedge clk)
    begin
        if (do_push)
            slot_reg[wr_ptr_reg] <= q_desc_in;
    end

    assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CNT_FULL)
        else $error("queue count beyond depth");

    assert property (@(posedge clk) disable iff (!rst_n)
        q_push |-> !q_full)
        else $error("push into full queue");

    assert property (@(posedge clk) disable iff (!rst_n)
        q_pop |-> q_valid)
        else $error("pop from empty queue");

endmodule

/* rtl/tccf_back.sv */
// Frame sequencer: walks the 13 words of each queued frame into an output register.
// Depends on tccf_pkg for the descriptor type and the color table.
module tccf_back (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 q_valid,
    input  tccf_pkg::frame_desc_t                q_desc,
    output logic                                 q_pop,
    input  logic                                 pop,
    output logic                                 empty,
    output logic [15:0]                          frame_word,
    output logic [tccf_pkg::WORD_IDX_W-1:0]      word_index,
    output logic                                 last_word
);
    import tccf_pkg::*;

    logic [WORD_IDX_W-1:0] word_cnt_reg, word_cnt_next;
    logic                  out_valid_reg, out_valid_next;
    logic [15:0]           frame_word_reg;
    logic [WORD_IDX_W-1:0] word_index_reg;
    logic                  last_word_reg;

    logic                  load;
    logic                  is_last;
    logic [3:0]            digit;
    logic [WORD_IDX_W-1:0] chan_full;
    logic [15:0]           word_value;

    // Refill the output register when it is free or being taken
    assign load    = q_valid && (!out_valid_reg || (pop && out_valid_reg));
    assign is_last = (word_cnt_reg == WORD_LAST);
    assign q_pop   = load && is_last;

    // Pick the digit and color channel for this position
    always_comb
    begin
        digit     = q_desc.sec_units;
        chan_full = '0;
        case (word_cnt_reg) inside
            [4'd1:4'd3]:
            begin
                digit     = q_desc.sec_units;
                chan_full = word_cnt_reg - 4'd1;
            end
            [4'd4:4'd6]:
            begin
                digit     = q_desc.sec_tens;
                chan_full = word_cnt_reg - 4'd4;
            end
            [4'd7:4'd9]:
            begin
                digit     = q_desc.min_units;
                chan_full = word_cnt_reg - 4'd7;
            end
            [4'd10:4'd12]:
            begin
                digit     = q_desc.sec_units;
                chan_full = word_cnt_reg - 4'd10;
            end
            default:
            begin
                digit     = q_desc.sec_units;
                chan_full = '0;
            end
        endcase
        word_value = (word_cnt_reg == WORD_CMD) ? q_desc.command
                                                : color_word(digit, chan_full[1:0]);
    end

    // Advance word position and output valid
    always_comb
    begin
        word_cnt_next  = word_cnt_reg;
        out_valid_next = out_valid_reg;
        if (load)
        begin
            word_cnt_next  = is_last ? WORD_CMD : word_cnt_reg + 1'b1;
            out_valid_next = 1'b1;
        end
        else if (pop && out_valid_reg)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            word_cnt_reg  <= WORD_CMD;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            word_cnt_reg  <= word_cnt_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Hold the outgoing word
    always_ff @(posedge clk)
    begin
        if (load)
        begin
            frame_word_reg <= word_value;
            word_index_reg <= word_cnt_reg;
            last_word_reg  <= is_last;
        end
    end

    assign empty      = !out_valid_reg;
    assign frame_word = frame_word_reg;
    assign word_index = word_index_reg;
    assign last_word  = last_word_reg;

    assert property (@(posedge clk) disable iff (!rst_n)
        word_cnt_reg <= WORD_LAST)
        else $error("word position beyond frame");

    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg |-> (last_word_reg == (word_index_reg == WORD_LAST)))
        else $error("last flag out of step with word index");

    assert property (@(posedge clk) disable iff (!rst_n)
        q_pop |=> (word_cnt_reg == WORD_CMD) && out_valid_reg && last_word_reg)
        else $error("frame released before its last word");

endmodule

/* rtl/tick_clock_color_frame.sv */
// Top level of the tick clock with LED color frame output.
// Instantiates tccf_front, tccf_queue and tccf_back; depends on tccf_pkg.
//
// Usage:
//   Input channel (push/full, field tick): one word per timer tick. A tick of
//   zero is taken and ignored. Ticks that do not complete a second produce
//   nothing; the tick that does produces one 13-word frame.
//   Output channel (empty/pop): frame_word, word_index 0..12, last_word on
//   word 12. A word is taken when pop is high and empty is low.
//   Config channel (cfg_valid/cfg_ready, always ready): index 0 tick_limit,
//   index 1 frame_command; other indexes are dropped. Write only when idle.
// Timing:
//   A firing tick is classified in the cycle it is taken; its descriptor
//   is queued, and its first word goes from the queue into the output register.
//   The sequencer then delivers one word per cycle while pop is held, all
//   through that single register. Ticks are taken every cycle as long as
//   the queue (QUEUE_DEPTH frames) has room; full rises when it is full.
// Reset: time 10:11:03, count 0, tick_limit 500, frame_command 0, no words.
// A stalled receiver holds the current word; the queue then fills and full
// rises, after which no tick is taken until words drain.
module tick_clock_color_frame #(
    parameter int QUEUE_DEPTH = tccf_pkg::QUEUE_DEPTH_DEFAULT
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                push,
    output logic                                full,
    input  logic                                tick,
    output logic                                empty,
    input  logic                                pop,
    output logic [15:0]                         frame_word,
    output logic [tccf_pkg::WORD_IDX_W-1:0]     word_index,
    output logic                                last_word,
    input  logic                                cfg_valid,
    output logic                                cfg_ready,
    input  logic [tccf_pkg::CFG_INDEX_W-1:0]    cfg_index,
    input  logic [tccf_pkg::CFG_DATA_W-1:0]     cfg_data
);
    import tccf_pkg::*;

    logic        q_full, q_push, q_pop, q_valid;
    frame_desc_t desc_in, desc_out;

    assign full      = q_full;
    assign cfg_ready = 1'b1;

    // Accept and classify ticks
    tccf_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .tick      (tick),
        .cfg_valid (cfg_valid),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .q_full    (q_full),
        .q_push    (q_push),
        .q_desc    (desc_in)
    );

    // Buffer pending frames
    tccf_queue #(
        .QUEUE_DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .q_push     (q_push),
        .q_desc_in  (desc_in),
        .q_full     (q_full),
        .q_pop      (q_pop),
        .q_valid    (q_valid),
        .q_desc_out (desc_out)
    );

    // Emit frame words
    tccf_back u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .q_valid    (q_valid),
        .q_desc     (desc_out),
        .q_pop      (q_pop),
        .pop        (pop),
        .empty      (empty),
        .frame_word (frame_word),
        .word_index (word_index),
        .last_word  (last_word)
    );

endmodule

/* tb/tccf_frame_checker.sv */
// Frame checker for the tick clock: watches the tick, result and register channels.
// Predicts every LED frame word and compares it with the word popped from the block.
// Depends on tccf_pkg for the register enum and the frame size.
module tccf_frame_checker (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             push,
    input  logic                             full,
    input  logic                             tick,
    input  logic                             empty,
    input  logic                             pop,
    input  logic [15:0]                      frame_word,
    input  logic [tccf_pkg::WORD_IDX_W-1:0]  word_index,
    input  logic                             last_word,
    input  logic                             cfg_valid,
    input  logic                             cfg_ready,
    input  logic [tccf_pkg::CFG_INDEX_W-1:0] cfg_index,
    input  logic [tccf_pkg::CFG_DATA_W-1:0]  cfg_data,
    output int                               fail_count,
    output int                               words_pending
);
    import tccf_pkg::*;

    localparam logic [15:0] LIMIT_AT_RESET   = 16'd500;
    localparam logic [15:0] COMMAND_AT_RESET = 16'h0000;
    localparam logic [5:0]  SECONDS_AT_RESET = 6'd3;
    localparam logic [5:0]  MINUTES_AT_RESET = 6'd11;
    localparam logic [4:0]  HOURS_AT_RESET   = 5'd10;
    localparam int          PRINT_CAP        = 50;

    // Resistor color code: black, brown, red, orange, yellow, green, blue,
    // violet, gray, white; red, green, blue channel per digit
    localparam logic [15:0] RESISTOR_RGB [10][3] = '{
        '{16'h0000, 16'h0000, 16'h0000},
        '{16'h8CCC, 16'h2666, 16'h0000},
        '{16'hFFFF, 16'h0000, 16'h0000},
        '{16'hFFFF, 16'hA665, 16'h0000},
        '{16'hFFFF, 16'hFFFF, 16'h0000},
        '{16'h0000, 16'hFFFF, 16'h0000},
        '{16'h0000, 16'h0000, 16'hFFFF},
        '{16'hEE13, 16'h828E, 16'hEE13},
        '{16'h3333, 16'h3333, 16'h3333},
        '{16'hFFFF, 16'hFFFF, 16'hFFFF}
    };

    typedef struct {
        logic [15:0]           value;
        logic [WORD_IDX_W-1:0] index;
        logic                  last;
    } led_word_t;

    led_word_t   expected_words [$];
    logic [15:0] limit_reg;
    logic [15:0] command_reg;
    logic [15:0] tick_count;
    logic [5:0]  seconds;
    logic [5:0]  minutes;
    logic [4:0]  hours;

    task automatic report_mismatch(input string what, input logic [15:0] got,
                                   input logic [15:0] want);
        fail_count++;
        if (fail_count <= PRINT_CAP)
            $display("%0t: mismatch on %s: got %h, want %h", $time, what, got, want);
    endtask

    task automatic queue_word(input logic [15:0] value, input int pos);
        led_word_t w;
        w.value = value;
        w.index = WORD_IDX_W'(pos);
        w.last  = (pos == FRAME_WORDS - 1);
        expected_words.push_back(w);
    endtask

    // Count one tick; on a completed second queue the frame, then advance the time
    task automatic count_tick_and_frame(input logic tick_bit);
        logic [15:0] old_count;
        logic [3:0]  shown [4];
        logic [3:0]  digit;
        if (!tick_bit)
            return;
        old_count  = tick_count;
        tick_count = old_count + 16'd1;
        if (old_count < limit_reg)
            return;
        tick_count = '0;

        // seconds units, seconds tens, minutes units, seconds units again
        shown[0] = 4'(seconds % 6'd10);
        shown[1] = 4'(seconds / 6'd10);
        shown[2] = 4'(minutes % 6'd10);
        shown[3] = shown[0];
        queue_word(command_reg, 0);
        for (int slot = 0; slot < 4; slot++)
        begin
            digit = (shown[slot] > 4'd9) ? 4'd9 : shown[slot];
            for (int ch = 0; ch < 3; ch++)
                queue_word(RESISTOR_RGB[digit][ch], 1 + slot * 3 + ch);
        end

        // advance with wrap at 60 / 60 / 24
        seconds = seconds + 6'd1;
        if (seconds >= 6'd60)
        begin
            seconds = '0;
            minutes = minutes + 6'd1;
        end
        if (minutes >= 6'd60)
        begin
            minutes = '0;
            hours   = hours + 5'd1;
        end
        if (hours >= 5'd24)
            hours = '0;
    endtask

    // Sample all channels at the rising edge
    always @(posedge clk)
    begin
        if (!rst_n)
        begin
            limit_reg   = LIMIT_AT_RESET;
            command_reg = COMMAND_AT_RESET;
            tick_count  = '0;
            seconds     = SECONDS_AT_RESET;
            minutes     = MINUTES_AT_RESET;
            hours       = HOURS_AT_RESET;
            expected_words.delete();
        end
        else
        begin
            // register writes; unknown indexes drop
            if (cfg_valid && cfg_ready)
            begin
                case (cfg_index)
                    CFG_TICK_LIMIT:    limit_reg   = cfg_data;
                    CFG_FRAME_COMMAND: command_reg = cfg_data;
                    default: ;
                endcase
            end

            // compare the popped word with the oldest expectation
            if (pop && !empty)
            begin
                if (expected_words.size() == 0)
                    report_mismatch("word with nothing expected", frame_word, 16'h0000);
                else
                begin
                    led_word_t want;
                    want = expected_words.pop_front();
                    if (frame_word !== want.value)
                        report_mismatch("frame_word", frame_word, want.value);
                    if (word_index !== want.index)
                        report_mismatch("word_index", 16'(word_index), 16'(want.index));
                    if (last_word !== want.last)
                        report_mismatch("last_word", 16'(last_word), 16'(want.last));
                end
            end

            if (push && !full)
                count_tick_and_frame(tick);
        end
        words_pending = expected_words.size();
    end

endmodule

/* tb/tb_top.sv */
// Top of the tick clock testbench: clock, reset, tick and register stimulus, verdict.
// Instantiates tick_clock_color_frame and tccf_frame_checker; depends on tccf_pkg.
module tb_top;
    import tccf_pkg::*;

    localparam logic [CFG_INDEX_W-1:0] CFG_INDEX_SPARE = 8'hFF;
    localparam int CYCLE_LIMIT   = 200000;
    localparam int SETTLE_CYCLES = 10;
    localparam int HOLD_CYCLES   = 300;
    localparam int PHASES        = 8;
    localparam int PHASE_TICKS   = 28;
    localparam int RESET_TICKS   = 200;

    logic clk = 1'b0;
    logic rst_n;
    logic push;
    logic full;
    logic tick;
    logic empty;
    logic pop;
    logic [15:0] frame_word;
    logic [WORD_IDX_W-1:0] word_index;
    logic last_word;
    logic cfg_valid;
    logic cfg_ready;
    logic [CFG_INDEX_W-1:0] cfg_index;
    logic [CFG_DATA_W-1:0] cfg_data;

    int fail_count;
    int words_pending;
    int cycle_count = 0;
    logic tx_idle_on = 1'b1;
    logic rx_idle_on = 1'b1;
    logic hold_request = 1'b0;

    tick_clock_color_frame dut (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .full       (full),
        .tick       (tick),
        .empty      (empty),
        .pop        (pop),
        .frame_word (frame_word),
        .word_index (word_index),
        .last_word  (last_word),
        .cfg_valid  (cfg_valid),
        .cfg_ready  (cfg_ready),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data)
    );

    tccf_frame_checker checker_i (
        .clk           (clk),
        .rst_n         (rst_n),
        .push          (push),
        .full          (full),
        .tick          (tick),
        .empty         (empty),
        .pop           (pop),
        .frame_word    (frame_word),
        .word_index    (word_index),
        .last_word     (last_word),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data),
        .fail_count    (fail_count),
        .words_pending (words_pending)
    );

    always
    begin
        #10 clk = 1'b1;
        #10 clk = 1'b0;
    end

    // Abort a hung run
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT)
        begin
            $display("TEST FAILED");
            $finish;
        end
    end

    // Receiver: random stall bursts, plus one long hold on request
    initial
    begin : receiver
        int stall_left;
        int hold_left;
        stall_left = 0;
        hold_left  = 0;
        pop = 1'b0;
        forever
        begin
            @(negedge clk);
            if (hold_request)
            begin
                hold_left    = HOLD_CYCLES;
                hold_request = 1'b0;
            end
            if (hold_left > 0)
            begin
                pop <= 1'b0;
                hold_left--;
            end
            else if (stall_left > 0)
            begin
                pop <= 1'b0;
                stall_left--;
            end
            else if (rx_idle_on && $urandom_range(0, 5) == 0)
            begin
                pop <= 1'b0;
                stall_left = $urandom_range(0, 5);
            end
            else
                pop <= 1'b1;
        end
    end

    // Offer one tick word, possibly after an idle burst; return at a falling edge
    task automatic send_tick(input logic value);
        if (tx_idle_on && $urandom_range(0, 4) == 0)
        begin
            push <= 1'b0;
            repeat ($urandom_range(1, 6)) @(negedge clk);
        end
        push <= 1'b1;
        tick <= value;
        do
            @(posedge clk);
        while (full);
        @(negedge clk);
    endtask

    // Send ticks at random, mostly ones, until the given number of ones went in
    task automatic send_random_ticks(input int ones);
        int sent;
        logic value;
        sent = 0;
        while (sent < ones)
        begin
            value = ($urandom_range(0, 7) != 0);
            send_tick(value);
            if (value)
                sent++;
        end
    endtask

    // Drop push, wait for every expected word, then let the block settle
    task automatic drain_frames();
        push <= 1'b0;
        while (words_pending != 0)
            @(negedge clk);
        repeat (SETTLE_CYCLES) @(negedge clk);
    endtask

    task automatic write_reg(input logic [CFG_INDEX_W-1:0] index,
                             input logic [CFG_DATA_W-1:0] data);
        cfg_valid <= 1'b1;
        cfg_index <= index;
        cfg_data  <= data;
        do
            @(posedge clk);
        while (!cfg_ready);
        @(negedge clk);
        cfg_valid <= 1'b0;
        @(negedge clk);
    endtask

    task automatic program_clock(input logic [15:0] limit, input logic [15:0] command);
        write_reg(CFG_TICK_LIMIT, limit);
        write_reg(CFG_FRAME_COMMAND, command);
    endtask

    initial
    begin : stimulus
        int r;
        logic [15:0] limit;
        rst_n     = 1'b0;
        push      = 1'b0;
        tick      = 1'b0;
        cfg_valid = 1'b0;
        cfg_index = '0;
        cfg_data  = '0;
        repeat (4) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // reset values: limit 500 holds back every frame for a while
        send_tick(1'b0);
        repeat (RESET_TICKS) send_tick(1'b1);
        drain_frames();

        // drop the limit below the count: next tick shows command 0 at 10:11:03
        write_reg(CFG_TICK_LIMIT, 16'd150);
        send_tick(1'b1);
        drain_frames();

        // limit of zero: every tick fires; all-ones command
        program_clock(16'd0, 16'hFFFF);
        send_tick(1'b1);
        send_tick(1'b0);
        repeat (3) send_tick(1'b1);
        drain_frames();

        // largest limit: no frame, count grows
        program_clock(16'hFFFF, 16'hA5A5);
        repeat (5) send_tick(1'b1);
        drain_frames();

        // lower the limit below the count: next tick fires
        write_reg(CFG_TICK_LIMIT, 16'd2);
        repeat (3) send_tick(1'b1);
        drain_frames();

        // unknown register index is dropped
        write_reg(CFG_INDEX_SPARE, 16'h1234);
        repeat (3) send_tick(1'b1);
        drain_frames();

        // random phases with fresh settings each
        for (int p = 0; p < PHASES; p++)
        begin
            r = $urandom_range(0, 9);
            if (r < 5)
                limit = 16'($urandom_range(0, 3));
            else if (r < 8)
                limit = 16'($urandom_range(4, 12));
            else
                limit = 16'($urandom_range(13, 40));
            if (p == 2)
                limit = 16'd0;
            if (p == PHASES - 1)
            begin
                tx_idle_on = 1'b0;
                rx_idle_on = 1'b0;
            end
            program_clock(limit, 16'($urandom));
            if ($urandom_range(0, 2) == 0)
                write_reg(CFG_INDEX_W'($urandom_range(2, 255)), 16'($urandom));
            // hold the receiver so the frame queue fills and full rises
            if (p == 2)
                hold_request = 1'b1;
            send_random_ticks(PHASE_TICKS);
            drain_frames();
        end

        if (fail_count == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

endmodule

/* tick_clock_color_frame.f */
rtl/tccf_pkg.sv
rtl/tccf_front.sv
rtl/tccf_queue.sv
rtl/tccf_back.sv
rtl/tick_clock_color_frame.sv
tb/tccf_frame_checker.sv
tb/tb_top.sv
